// ----- hdl/hpt_pkg.sv -----
// hpt_pkg: types and constants shared by the homogeneous point transform core
// request/response payload structs, mode codes, lane control struct
// no dependencies
package hpt_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] prod_type;
   typedef word_type [3:0]     quad_type;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_FULL   = 2'd1;
   localparam logic [1:0] MODE_ROT    = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] row_index;
      logic [1:0] col_index;
      word_type   coeff_value;
      word_type   in_x;
      word_type   in_y;
      word_type   in_z;
      word_type   in_w;
   } req_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
   } rsp_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic rot;
   } lane_ctl_type;

endpackage

// ----- hdl/hpt_lane.sv -----
// hpt_lane: one matrix row times the point, three register stages
// multiply, pair add, final add with floor shift and saturation
// depends on hpt_pkg
module hpt_lane import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  lane_ctl_type ctl,
   input  quad_type     coeff_row,
   input  quad_type     vec,
   output word_type     result
);

   prod_type [3:0]     prod_in, prod_ff;
   logic signed [64:0] pair_in [2];
   logic signed [64:0] pair_ff [2];
   logic signed [65:0] sum_w;
   logic signed [65:0] shifted_w;
   word_type           result_in, result_ff;

   // w column drops out in rotation-only mode
   always_comb begin
      word_type ce;
      for (int c = 0; c < 4; c++) begin
         ce = ((c == 3) && ctl.rot) ? '0 : coeff_row[c];
         prod_in[c] = ce * vec[c];
      end
   end

   always_comb begin
      pair_in[0] = 65'(prod_ff[0]) + 65'(prod_ff[1]);
      pair_in[1] = 65'(prod_ff[2]) + 65'(prod_ff[3]);
   end

   always_comb begin
      sum_w     = 66'(pair_ff[0]) + 66'(pair_ff[1]);
      shifted_w = sum_w >>> FRAC_BITS;
      if ((&shifted_w[65:31]) || !(|shifted_w[65:31])) begin
         result_in = shifted_w[31:0];
      end else if (shifted_w[65]) begin
         result_in = {1'b1, 31'd0};
      end else begin
         result_in = {1'b0, {31{1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         prod_ff <= prod_in;
      end
      if (ctl.en2) begin
         pair_ff <= pair_in;
      end
      if (ctl.en3) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- hdl/hpt_merge.sv -----
// hpt_merge: collects the four lane results into the response register
// forces w to zero for rotation-only requests
// depends on hpt_pkg
module hpt_merge import hpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     lane_valid,
   input  logic     lane_rot,
   input  quad_type lane_result,
   output logic     out_ready,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic    valid_in, valid_ff;
   rsp_type data_in, data_ff;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = out_ready ? lane_valid : valid_ff;
      data_in.out_x = lane_result[0];
      data_in.out_y = lane_result[1];
      data_in.out_z = lane_result[2];
      data_in.out_w = lane_rot ? '0 : lane_result[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (out_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- hdl/homogeneous_point_transform_core.sv -----
// homogeneous_point_transform_core: 4x4 Q-format matrix times homogeneous point
// holds the coefficient matrix, request pipeline control, four row lanes and merge
// depends on hpt_pkg, hpt_lane, hpt_merge
//
//   port group | dir | payload   | handshake
//   -----------+-----+-----------+------------------------------------
//   req_       | in  | req_type  | req_valid / req_stall (we drive stall)
//   rsp_       | out | rsp_type  | rsp_valid / rsp_stall (sink drives stall)
//
// one request per cycle while req_stall is low, loads and transforms alike; a transform's
// response passes the multiply, pair add and final add/saturate registers and then the
// output reg; the multiply register loads at the accepting edge
// four row lanes run in parallel, each with four 32x32 multipliers
// reset puts the matrix back to identity and empties the pipeline
// a stalled response holds the pipeline; bubbles collapse so up to 4 transforms queue
module homogeneous_point_transform_core import hpt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam word_type ONE = word_type'(64'd1 << FRAC_BITS);

   word_type [15:0] coeff_in, coeff_ff;
   quad_type        vec;
   quad_type        lane_result;
   lane_ctl_type    lane_ctl;

   logic accepted;
   logic is_xform;
   logic out_ready;
   logic s1_ready, s2_ready, s3_ready;
   logic v1_in, v1_ff, v2_in, v2_ff, v3_in, v3_ff;
   logic rot1_in, rot1_ff, rot2_in, rot2_ff, rot3_in, rot3_ff;

   // ready chain, each stage moves if empty or its successor moves
   assign s3_ready  = !v3_ff || out_ready;
   assign s2_ready  = !v2_ff || s3_ready;
   assign s1_ready  = !v1_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accepted  = req_valid && !req_stall;

   // only full and rotation-only requests make a response
   assign is_xform = (req_data.mode == MODE_FULL) || (req_data.mode == MODE_ROT);

   assign vec[0] = req_data.in_x;
   assign vec[1] = req_data.in_y;
   assign vec[2] = req_data.in_z;
   assign vec[3] = req_data.in_w;

   always_comb begin
      lane_ctl.en1 = s1_ready;
      lane_ctl.en2 = s2_ready;
      lane_ctl.en3 = s3_ready;
      lane_ctl.rot = (req_data.mode == MODE_ROT);
   end

   // valid / rotation flag pipeline alongside the lanes
   always_comb begin
      v1_in   = s1_ready ? (accepted && is_xform) : v1_ff;
      rot1_in = s1_ready ? lane_ctl.rot : rot1_ff;
      v2_in   = s2_ready ? v1_ff : v2_ff;
      rot2_in = s2_ready ? rot1_ff : rot2_ff;
      v3_in   = s3_ready ? v2_ff : v3_ff;
      rot3_in = s3_ready ? rot2_ff : rot3_ff;
   end

   // coefficient store, row-major, written by load requests
   always_comb begin
      coeff_in = coeff_ff;
      if (accepted && (req_data.mode == MODE_LOAD)) begin
         coeff_in[{req_data.row_index, req_data.col_index}] = req_data.coeff_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            coeff_ff[i] <= ((i % 5) == 0) ? ONE : '0;
         end
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         coeff_ff <= coeff_in;
      end
      rot1_ff <= rot1_in;
      rot2_ff <= rot2_in;
      rot3_ff <= rot3_in;
   end

   // one lane per output row
   for (genvar r = 0; r < 4; r++) begin : g_lane
      hpt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock     (clock),
         .ctl       (lane_ctl),
         .coeff_row (coeff_ff[4*r +: 4]),
         .vec       (vec),
         .result    (lane_result[r])
      );
   end

   hpt_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .lane_valid  (v3_ff),
      .lane_rot    (rot3_ff),
      .lane_result (lane_result),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   // stall only comes from a full first stage
   a_stall_needs_s1: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("request stalled with empty first stage");

   // a load lands in the addressed coefficient
   a_load_writes: assert property (@(posedge clock) disable iff (reset)
      (accepted && (req_data.mode == MODE_LOAD)) |=>
      (coeff_ff[$past({req_data.row_index, req_data.col_index})] ==
       $past(req_data.coeff_value)))
      else $error("coefficient load lost");

   // a taken response with nothing behind it empties the output
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !v3_ff) |=> !rsp_valid)
      else $error("response repeated");

   // non-transform requests never enter the pipeline
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (s1_ready && !(accepted && is_xform)) |=> !v1_ff)
      else $error("spurious pipeline entry");

endmodule
